// File: hdl/mciir_pkg.sv
// Shared types and fixed constants of the multichannel IIR filter.
package mciir_pkg;

   // Field widths fixed by the request and response formats.
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int ACC_W       = 64;
   localparam int FRAC_SHIFT  = 24;
   localparam int RND_W       = ACC_W - FRAC_SHIFT;
   localparam int TAPREG_W    = 5;
   localparam int CSR_INDEX_W = 2;

   // Request function codes.
   localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_FF = 2'd1;
   localparam logic [1:0] FUNC_LOAD_FB = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FF_TAPS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FB_TAPS = 2'd1;

   // Rounding offset (half an output LSB in Q.47) and the Q1.23 saturation limits.
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd8388608);
   localparam logic signed [RND_W-1:0] Q_MAX      = RND_W'(8388607);
   localparam logic signed [RND_W-1:0] Q_MIN      = RND_W'(-8388608);

   // One request: a sample to filter or a coefficient to load.
   typedef struct packed {
      logic [1:0]                 func;
      logic [2:0]                 channel;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [4:0]                 coef_index;
      logic signed [COEF_W-1:0]   coef_value;
   } req_type;

   // One response: a filtered sample.
   typedef struct packed {
      logic [2:0]                 out_channel;
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } rsp_type;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic valid;
      logic neg;
   } mac_ctl_type;

   // History update at the end of a sample.
   typedef struct packed {
      logic                       push;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
   } hist_push_type;

endpackage

// File: hdl/multichannel_iir_filter_top.sv
// Top level of the multichannel direct-form-I IIR filter: sequencer and response register.
//
//   Channel   Ports                                   Moves
//   request   req_valid, req_ready, req_payload       sample or coefficient load
//   response  rsp_valid, rsp_ready, rsp_payload       filtered sample of one channel
//   config    csr_we, csr_index, csr_wdata            feedforward / feedback tap counts
//
// A sample runs nf feedforward and max(nb - 1, 0) feedback terms, with both tap counts
// capped at MAX_TAPS, then rounds and saturates before the response is loaded and the block
// is ready again; the one multiply-accumulate unit takes a term per cycle.
// Coefficient loads and dropped requests finish in the accepting cycle and leave the block ready.
// Reset clears coefficients, tap counts (to one) and the history fill counts at once.
// A stalled response holds the sequencer in its last step until the response is taken.
module multichannel_iir_filter_top #(
   parameter int CHANNELS = 8,
   parameter int MAX_TAPS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mciir_pkg::req_type                   req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mciir_pkg::rsp_type                   rsp_payload,
   input  logic                                 csr_we,
   input  logic [mciir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mciir_pkg::TAPREG_W-1:0]       csr_wdata
);

   localparam int HIST = MAX_TAPS - 1;
   localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW   = (HIST > 1) ? $clog2(HIST) : 1;
   localparam int FW   = $clog2(HIST + 1);
   localparam int KW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TW   = $clog2(MAX_TAPS + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_FF    = 3'd2;
   localparam logic [2:0] S_FB    = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_ROUND = 3'd5;
   localparam logic [2:0] S_SAT   = 3'd6;

   logic [2:0]                                  state_ff, state_in;
   logic [mciir_pkg::TAPREG_W-1:0]              ff_taps_ff, fb_taps_ff;
   logic [2:0]                                  chan_ff;
   logic signed [mciir_pkg::SAMPLE_W-1:0]       x_ff;
   logic [TW-1:0]                               nf_ff, nb_ff;
   logic [KW-1:0]                               k_ff, k_in;
   logic [PW-1:0]                               pos_ff, pos_in;
   logic                                        tok_valid_ff, tok_neg_ff, tok_usex_ff;
   logic signed [mciir_pkg::RND_W-1:0]          rnd_ff;
   logic                                        rsp_valid_ff;
   mciir_pkg::rsp_type                          rsp_ff;

   logic                                        req_fire;
   logic                                        is_load;
   logic                                        coef_wr;
   logic                                        sample_go;
   logic                                        hist_clear;
   logic                                        issue, issue_neg, issue_usex, rd_live;
   logic                                        mac_clear;
   logic                                        rsp_load;
   logic [PW-1:0]                               head;
   logic [FW-1:0]                               fill;
   logic [PW-1:0]                               pos_dec;
   logic                                        term_live;
   logic                                        nf_last, nb_last;
   logic signed [mciir_pkg::COEF_W-1:0]         coef_rd;
   logic signed [mciir_pkg::SAMPLE_W-1:0]       past_in, past_out, mac_samp;
   logic signed [mciir_pkg::ACC_W-1:0]          acc;
   logic signed [mciir_pkg::ACC_W-1:0]          acc_rnd;
   logic                                        mac_busy;
   logic                                        over, under;
   logic signed [mciir_pkg::SAMPLE_W-1:0]       q_sat;
   mciir_pkg::mac_ctl_type                      mac_ctl;
   mciir_pkg::hist_push_type                    hist_push;

   // A tap count above the number of stored coefficients is capped.
   function automatic logic [TW-1:0] tap_cap(input logic [mciir_pkg::TAPREG_W-1:0] r);
      return (int'(r) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(r);
   endfunction

   // Request decode: loads and dropped requests finish in the accepting cycle.
   always_comb begin
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;
      is_load   = (req_payload.func == mciir_pkg::FUNC_LOAD_FF) ||
                  (req_payload.func == mciir_pkg::FUNC_LOAD_FB);
      coef_wr   = req_fire && is_load && (int'(req_payload.coef_index) < MAX_TAPS);
      sample_go = req_fire && (req_payload.func == mciir_pkg::FUNC_SAMPLE) &&
                  (int'(req_payload.channel) < CHANNELS);
      hist_clear = coef_wr || (csr_we && ((csr_index == mciir_pkg::CSR_FF_TAPS) ||
                                          (csr_index == mciir_pkg::CSR_FB_TAPS)));
   end

   // Tap count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_taps_ff <= mciir_pkg::TAPREG_W'(1);
         fb_taps_ff <= mciir_pkg::TAPREG_W'(1);
      end else if (csr_we) begin
         if (csr_index == mciir_pkg::CSR_FF_TAPS) begin
            ff_taps_ff <= csr_wdata;
         end else if (csr_index == mciir_pkg::CSR_FB_TAPS) begin
            fb_taps_ff <= csr_wdata;
         end
      end
   end

   // Per-sample operands, latched when the sample is accepted.
   always_ff @(posedge clock) begin
      if (sample_go) begin
         chan_ff <= req_payload.channel;
         x_ff    <= req_payload.sample_in;
         nf_ff   <= tap_cap(ff_taps_ff);
         nb_ff   <= tap_cap(fb_taps_ff);
      end
   end

   // Term bookkeeping: history slot walks back from the newest entry.
   always_comb begin
      pos_dec   = (pos_ff == '0) ? PW'(HIST - 1) : pos_ff - PW'(1);
      term_live = (TW'(k_ff - KW'(1)) < TW'(fill));
      nf_last   = (TW'(k_ff) == nf_ff - TW'(1));
      nb_last   = (TW'(k_ff) == nb_ff - TW'(1));
   end

   // Sequencer: one term issued to the multiply-accumulate unit per cycle.
   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      pos_in     = pos_ff;
      issue      = 1'b0;
      issue_neg  = 1'b0;
      issue_usex = 1'b0;
      rd_live    = 1'b0;
      mac_clear  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (sample_go) begin
               state_in = S_START;
            end
         end
         S_START: begin
            mac_clear = 1'b1;
            pos_in    = head;
            if (nf_ff != '0) begin
               k_in     = '0;
               state_in = S_FF;
            end else if (nb_ff > TW'(1)) begin
               k_in     = KW'(1);
               state_in = S_FB;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_FF: begin
            issue = 1'b1;
            if (k_ff == '0) begin
               issue_usex = 1'b1;
            end else begin
               rd_live = term_live;
               pos_in  = pos_dec;
            end
            if (nf_last) begin
               pos_in = head;
               if (nb_ff > TW'(1)) begin
                  k_in     = KW'(1);
                  state_in = S_FB;
               end else begin
                  state_in = S_DRAIN;
               end
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_FB: begin
            issue     = 1'b1;
            issue_neg = 1'b1;
            rd_live   = term_live;
            pos_in    = pos_dec;
            if (nb_last) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + KW'(1);
            end
         end
         S_DRAIN: begin
            if (!tok_valid_ff && !mac_busy) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_SAT;
         end
         S_SAT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tok_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tok_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      tok_neg_ff  <= issue_neg;
      tok_usex_ff <= issue_usex;
   end

   // Operand selection in the cycle after issue, when the memory data is out.
   always_comb begin
      if (tok_usex_ff) begin
         mac_samp = x_ff;
      end else if (tok_neg_ff) begin
         mac_samp = past_out;
      end else begin
         mac_samp = past_in;
      end
      mac_ctl.clear = mac_clear;
      mac_ctl.valid = tok_valid_ff;
      mac_ctl.neg   = tok_neg_ff;
   end

   // Round half up to Q1.23, then saturate.
   assign acc_rnd = acc + mciir_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (state_ff == S_ROUND) begin
         rnd_ff <= acc_rnd[mciir_pkg::ACC_W-1:mciir_pkg::FRAC_SHIFT];
      end
   end

   always_comb begin
      over  = (rnd_ff > mciir_pkg::Q_MAX);
      under = (rnd_ff < mciir_pkg::Q_MIN);
      if (over) begin
         q_sat = mciir_pkg::Q_MAX[mciir_pkg::SAMPLE_W-1:0];
      end else if (under) begin
         q_sat = mciir_pkg::Q_MIN[mciir_pkg::SAMPLE_W-1:0];
      end else begin
         q_sat = rnd_ff[mciir_pkg::SAMPLE_W-1:0];
      end
      hist_push.push = rsp_load;
      hist_push.x    = x_ff;
      hist_push.y    = q_sat;
   end

   // Response register: the result waits here until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.out_channel <= chan_ff;
         rsp_ff.sample_out  <= q_sat;
         rsp_ff.clipped     <= over || under;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mciir_coef #(
      .MAX_TAPS (MAX_TAPS)
   ) u_coef (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (coef_wr),
      .wr_back (req_payload.func == mciir_pkg::FUNC_LOAD_FB),
      .wr_addr (KW'(req_payload.coef_index)),
      .wr_data (req_payload.coef_value),
      .rd_back (state_ff == S_FB),
      .rd_addr (k_ff),
      .rd_data (coef_rd)
   );

   mciir_hist #(
      .CHANNELS (CHANNELS),
      .MAX_TAPS (MAX_TAPS)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .clear    (hist_clear),
      .chan     (CW'(chan_ff)),
      .head     (head),
      .fill     (fill),
      .rd_pos   (pos_ff),
      .rd_live  (rd_live),
      .past_in  (past_in),
      .past_out (past_out),
      .push     (hist_push)
   );

   mciir_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (coef_rd),
      .samp  (mac_samp),
      .acc   (acc),
      .busy  (mac_busy)
   );

endmodule

// File: hdl/mciir_coef.sv
// Feedforward and feedback coefficient register files with a registered read port.
module mciir_coef #(
   parameter int MAX_TAPS = 20,
   localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic                                  wr_back,
   input  logic [KW-1:0]                         wr_addr,
   input  logic signed [mciir_pkg::COEF_W-1:0]   wr_data,
   input  logic                                  rd_back,
   input  logic [KW-1:0]                         rd_addr,
   output logic signed [mciir_pkg::COEF_W-1:0]   rd_data
);

   logic signed [mciir_pkg::COEF_W-1:0] forward_ff  [MAX_TAPS];
   logic signed [mciir_pkg::COEF_W-1:0] backward_ff [MAX_TAPS];
   logic signed [mciir_pkg::COEF_W-1:0] rd_data_ff;

   // Coefficient writes; both sets are zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            forward_ff[i]  <= '0;
            backward_ff[i] <= '0;
         end
      end else if (wr_en) begin
         if (wr_back) begin
            backward_ff[wr_addr] <= wr_data;
         end else begin
            forward_ff[wr_addr] <= wr_data;
         end
      end
   end

   // Registered read, aligned with the history memory read.
   always_ff @(posedge clock) begin
      rd_data_ff <= rd_back ? backward_ff[rd_addr] : forward_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mciir_hist.sv
// Per-channel input and output history kept as circular buffers in two memories.
module mciir_hist #(
   parameter int CHANNELS = 8,
   parameter int MAX_TAPS = 20,
   localparam int HIST  = MAX_TAPS - 1,
   localparam int DEPTH = CHANNELS * HIST,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int PW    = (HIST > 1) ? $clog2(HIST) : 1,
   localparam int FW    = $clog2(HIST + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic [CW-1:0]                         chan,
   output logic [PW-1:0]                         head,
   output logic [FW-1:0]                         fill,
   input  logic [PW-1:0]                         rd_pos,
   input  logic                                  rd_live,
   output logic signed [mciir_pkg::SAMPLE_W-1:0] past_in,
   output logic signed [mciir_pkg::SAMPLE_W-1:0] past_out,
   input  mciir_pkg::hist_push_type              push
);

   logic [mciir_pkg::SAMPLE_W-1:0] past_inputs_ff  [DEPTH];
   logic [mciir_pkg::SAMPLE_W-1:0] past_outputs_ff [DEPTH];
   logic [PW-1:0] head_ff [CHANNELS];
   logic [FW-1:0] fill_ff [CHANNELS];
   logic [mciir_pkg::SAMPLE_W-1:0] in_rd_ff;
   logic [mciir_pkg::SAMPLE_W-1:0] out_rd_ff;
   logic live_ff;
   logic [PW-1:0] wr_pos;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   assign head = head_ff[chan];
   assign fill = fill_ff[chan];

   // The next write slot follows the most recent entry, wrapping at the buffer length.
   always_comb begin
      wr_pos  = (head == PW'(HIST - 1)) ? '0 : head + PW'(1);
      rd_addr = AW'(int'(chan) * HIST + int'(rd_pos));
      wr_addr = AW'(int'(chan) * HIST + int'(wr_pos));
   end

   // Head pointer and fill count per channel; a clear empties every channel at once.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < CHANNELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (push.push) begin
         head_ff[chan] <= wr_pos;
         if (fill != FW'(HIST)) begin
            fill_ff[chan] <= fill + FW'(1);
         end
      end
   end

   // History memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (push.push) begin
         past_inputs_ff[wr_addr]  <= push.x;
         past_outputs_ff[wr_addr] <= push.y;
      end
      in_rd_ff  <= past_inputs_ff[rd_addr];
      out_rd_ff <= past_outputs_ff[rd_addr];
      live_ff   <= rd_live;
   end

   // Entries older than the fill count read as zero; the memories themselves are not cleared.
   assign past_in  = live_ff ? signed'(in_rd_ff) : '0;
   assign past_out = live_ff ? signed'(out_rd_ff) : '0;

endmodule

// File: hdl/mciir_mac.sv
// Shared multiply-accumulate unit: registered product, then a 64-bit add or subtract.
module mciir_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mciir_pkg::mac_ctl_type                ctl,
   input  logic signed [mciir_pkg::COEF_W-1:0]   coef,
   input  logic signed [mciir_pkg::SAMPLE_W-1:0] samp,
   output logic signed [mciir_pkg::ACC_W-1:0]    acc,
   output logic                                  busy
);

   logic signed [mciir_pkg::PROD_W-1:0] prod_ff;
   logic signed [mciir_pkg::PROD_W-1:0] prod_in;
   logic                                pvalid_ff;
   logic                                pneg_ff;
   logic signed [mciir_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mciir_pkg::ACC_W-1:0]  acc_in;
   logic signed [mciir_pkg::ACC_W-1:0]  prod_ext;

   // Exact Q.47 product of a coefficient and a sample.
   assign prod_in = coef * samp;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pneg_ff <= ctl.neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= ctl.valid;
      end
   end

   // Feedback terms are subtracted, feedforward terms added.
   always_comb begin
      prod_ext = mciir_pkg::ACC_W'(prod_ff);
      acc_in   = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pvalid_ff) begin
         acc_in = pneg_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign busy = pvalid_ff;

endmodule

// File: hdl/mciir_checker.sv
// Port-level checks of the IIR filter and their binding to the top level.
module mciir_checker #(
   parameter int CHANNELS = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input mciir_pkg::req_type                req_payload,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input mciir_pkg::rsp_type                rsp_payload
);

   logic sample_fire;
   assign sample_fire = req_valid && req_ready &&
                        (req_payload.func == mciir_pkg::FUNC_SAMPLE) &&
                        (int'(req_payload.channel) < CHANNELS);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // A sample occupies the filter, so no request is taken in the next cycle.
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> !req_ready)
      else $error("request taken right after a sample");

   // Any other request finishes at once and leaves the filter ready.
   a_load_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !sample_fire |=> req_ready)
      else $error("non-sample request made the filter busy");

   // A new response only comes at the end of a sample's computation.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a sample in progress");

   // The clip flag goes with a value at a saturation limit.
   a_clip_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.clipped |->
         (rsp_payload.sample_out == 24'sh7FFFFF) || (rsp_payload.sample_out == 24'sh800000))
      else $error("clipped response not at a limit");

endmodule

bind multichannel_iir_filter_top mciir_checker #(.CHANNELS(CHANNELS)) u_mciir_checker (.*);
